>>> src/mct_pkg.sv
// shared constants, types and helpers for the mirror coordinate transform
package mct_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int DIV_STEPS     = 64;
    localparam int XY_W          = 36;
    localparam int Z_W           = 33;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097150,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
        32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
    };

    localparam logic [1:0] CFG_UNIFORM = 2'd0;
    localparam logic [1:0] CFG_CURV    = 2'd1;
    localparam logic [1:0] CFG_SPACING = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DOMAIN = 2'd1;
    localparam logic [1:0] ST_SAT    = 2'd2;

    localparam logic [1:0] OP_DONE = 2'd0;
    localparam logic [1:0] OP_DIVU = 2'd1;
    localparam logic [1:0] OP_ATAN = 2'd2;
    localparam logic [1:0] OP_TAN  = 2'd3;

    localparam logic       CMD_TO_CURV = 1'b0;
    localparam logic       CMD_TO_CART = 1'b1;

    localparam logic [32:0] RES_SAT = '1;

    typedef struct packed {
        logic        neg;
        logic [1:0]  op;
        logic [1:0]  st;
        logic [32:0] res;
    } t_ctx;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   vec;
    } t_rot;

    // magnitude squeezed to 33 bits, anything too big marked saturated
    function automatic logic [32:0] f_code33(input logic [63:0] v);
        return (v[63:33] != '0) ? RES_SAT : v[32:0];
    endfunction

endpackage

>>> src/mct_in_if.sv
// input channel of the mirror coordinate transform
interface mct_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] coord_in;

    modport source (output valid, output cmd, output coord_in, input ready);
    modport sink (input valid, input cmd, input coord_in, output ready);
endinterface

>>> src/mct_out_if.sv
// result channel of the mirror coordinate transform
interface mct_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coord_out;
    logic [1:0]         status;

    modport source (output valid, output coord_out, output status, input ready);
    modport sink (input valid, input coord_out, input status, output ready);
endinterface

>>> src/mct_prep.sv
// front stages: magnitude, products, case decode, angle and atan operand setup
module mct_prep import mct_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_cmd,
    input  logic signed [31:0] i_coord,
    input  logic               i_uniform,
    input  logic [31:0]        i_xi,
    input  logic [31:0]        i_d1,
    output logic               o_valid,
    output t_ctx               o_ctx,
    output t_rot               o_rot
);

    // stage 0: sign and magnitude
    logic        r0_v, r0_cmd, r0_neg;
    logic [31:0] r0_mag;
    logic [31:0] n0_mag;

    assign n0_mag = i_coord[31] ? 32'(-i_coord) : 32'(i_coord);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
        if (i_en) begin
            r0_cmd <= i_cmd;
            r0_neg <= i_coord[31];
            r0_mag <= n0_mag;
        end
    end

    // stage 1: first products
    logic        r1_v, r1_cmd, r1_neg, r1_uni;
    logic [31:0] r1_mag;
    logic [63:0] r1_m1, r1_p;
    logic        n1_uni;
    logic [31:0] n1_mop;
    logic [63:0] n1_m1, n1_p;

    assign n1_uni = i_uniform | (i_xi == '0);
    assign n1_mop = n1_uni ? i_d1 : i_xi;
    assign n1_m1  = r0_mag * n1_mop;
    assign n1_p   = i_xi * i_d1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= r0_v;
        end
        if (i_en) begin
            r1_cmd <= r0_cmd;
            r1_neg <= r0_neg;
            r1_uni <= n1_uni;
            r1_mag <= r0_mag;
            r1_m1  <= n1_m1;
            r1_p   <= n1_p;
        end
    end

    // stage 2: angle partial products
    logic        r2_v, r2_cmd, r2_neg, r2_uni;
    logic [31:0] r2_mag;
    logic [63:0] r2_m1, r2_hi, r2_lo;
    logic [63:0] n2_hi, n2_lo;

    assign n2_hi = r1_p[63:32] * r1_mag;
    assign n2_lo = r1_p[31:0] * r1_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
        if (i_en) begin
            r2_cmd <= r1_cmd;
            r2_neg <= r1_neg;
            r2_uni <= r1_uni;
            r2_mag <= r1_mag;
            r2_m1  <= r1_m1;
            r2_hi  <= n2_hi;
            r2_lo  <= n2_lo;
        end
    end

    // stage 3: case decode
    logic        r3_v;
    t_ctx        r3_ctx;
    logic [63:0] r3_m1;
    logic [30:0] r3_theta;
    t_ctx        n3_ctx;
    logic [38:0] n3_theta;
    logic        n3_mag_zero, n3_d1_zero;

    assign n3_theta    = 39'({r2_hi[24:0], 6'b0}) + 39'(r2_lo[63:26]);
    assign n3_mag_zero = (r2_mag == '0);
    assign n3_d1_zero  = (i_d1 == '0);

    always_comb begin
        n3_ctx.neg = r2_neg;
        n3_ctx.op  = OP_DONE;
        n3_ctx.st  = ST_OK;
        n3_ctx.res = '0;
        if (r2_uni) begin
            if (r2_cmd == CMD_TO_CURV) begin
                if (n3_mag_zero) begin
                    n3_ctx.neg = 1'b0;
                end else if (n3_d1_zero) begin
                    n3_ctx.st  = ST_SAT;
                    n3_ctx.res = RES_SAT;
                end else begin
                    n3_ctx.op  = OP_DIVU;
                    n3_ctx.res = {1'b0, r2_mag};
                end
            end else begin
                n3_ctx.res = f_code33({16'b0, r2_m1[63:16]});
            end
        end else if (r2_cmd == CMD_TO_CURV) begin
            if (n3_mag_zero) begin
                n3_ctx.neg = 1'b0;
            end else if (n3_d1_zero) begin
                n3_ctx.st  = ST_SAT;
                n3_ctx.res = RES_SAT;
            end else begin
                n3_ctx.op = OP_ATAN;
            end
        end else begin
            if (n3_mag_zero || n3_d1_zero) begin
                n3_ctx.neg = 1'b0;
            end else if ((r2_hi[63:25] != '0) || (n3_theta >= 39'(HALF_PI_Q30))) begin
                n3_ctx.st  = ST_DOMAIN;
                n3_ctx.res = RES_SAT;
            end else if (n3_theta == '0) begin
                n3_ctx.neg = 1'b0;
            end else begin
                n3_ctx.op = OP_TAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
        if (i_en) begin
            r3_ctx   <= n3_ctx;
            r3_m1    <= r2_m1;
            r3_theta <= n3_theta[30:0];
        end
    end

    // stage 4: atan operand scaling and rotator start values
    logic        r4_v;
    t_ctx        r4_ctx;
    t_rot        r4_rot;
    t_ctx        n4_ctx;
    t_rot        n4_rot;
    logic [54:0] n4_v;
    logic [4:0]  n4_j;

    always_comb begin
        n4_v = r3_m1[63:9];
        n4_j = '0;
        for (int k = 4; k >= 0; k--) begin
            if ((n4_v >> (32 + (1 << k))) != '0) begin
                n4_v = n4_v >> (1 << k);
                n4_j = n4_j + 5'(1 << k);
            end
        end
        if (n4_v[54:32] != '0) begin
            n4_v = n4_v >> 1;
            n4_j = n4_j + 5'd1;
        end

        n4_ctx     = r3_ctx;
        n4_rot.vec = (r3_ctx.op == OP_ATAN);
        n4_rot.x   = $signed(36'd1 << 30);
        n4_rot.y   = '0;
        n4_rot.z   = $signed({2'b0, r3_theta});
        if (r3_ctx.op == OP_ATAN) begin
            n4_rot.x = $signed(36'd1 << (5'd31 - n4_j));
            n4_rot.y = $signed({4'b0, n4_v[31:0]});
            n4_rot.z = '0;
            if (n4_v[31:0] == '0) begin
                n4_ctx.op = OP_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
        if (i_en) begin
            r4_ctx <= n4_ctx;
            r4_rot <= n4_rot;
        end
    end

    assign o_valid = r4_v;
    assign o_ctx   = r4_ctx;
    assign o_rot   = r4_rot;

endmodule

>>> src/mct_cordic.sv
// pipelined cordic, one micro-rotation per stage, vectoring or rotation per item
module mct_cordic import mct_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_ctx i_ctx,
    input  t_rot i_rot,
    output logic o_valid,
    output t_ctx o_ctx,
    output t_rot o_rot
);

    logic r_v   [CORDIC_STAGES];
    t_ctx r_ctx [CORDIC_STAGES];
    t_rot r_rot [CORDIC_STAGES];
    logic w_v   [CORDIC_STAGES];
    t_ctx w_ctx [CORDIC_STAGES];
    t_rot w_src [CORDIC_STAGES];
    t_rot n_rot [CORDIC_STAGES];

    always_comb begin
        w_v[0]   = i_valid;
        w_ctx[0] = i_ctx;
        w_src[0] = i_rot;
        for (int k = 1; k < CORDIC_STAGES; k++) begin
            w_v[k]   = r_v[k-1];
            w_ctx[k] = r_ctx[k-1];
            w_src[k] = r_rot[k-1];
        end
    end

    always_comb begin
        logic                   up;
        logic signed [Z_W-1:0]  ang;
        for (int k = 0; k < CORDIC_STAGES; k++) begin
            ang = $signed({1'b0, ATAN_Q30[k]});
            up  = w_src[k].vec ? !(w_src[k].y > 0) : (w_src[k].z >= 0);
            n_rot[k].vec = w_src[k].vec;
            if (up) begin
                n_rot[k].x = w_src[k].x - (w_src[k].y >>> k);
                n_rot[k].y = w_src[k].y + (w_src[k].x >>> k);
                n_rot[k].z = w_src[k].z - ang;
            end else begin
                n_rot[k].x = w_src[k].x + (w_src[k].y >>> k);
                n_rot[k].y = w_src[k].y - (w_src[k].x >>> k);
                n_rot[k].z = w_src[k].z + ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CORDIC_STAGES; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v[k];
            end
            if (i_en) begin
                r_ctx[k] <= w_ctx[k];
                r_rot[k] <= n_rot[k];
            end
        end
    end

    assign o_valid = r_v[CORDIC_STAGES-1];
    assign o_ctx   = r_ctx[CORDIC_STAGES-1];
    assign o_rot   = r_rot[CORDIC_STAGES-1];

endmodule

>>> src/mct_div.sv
// pipelined restoring divider, one quotient bit per stage, starting remainder given
module mct_div import mct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_ctx        i_ctx,
    input  logic [63:0] i_rem,
    input  logic [63:0] i_dvd,
    input  logic [63:0] i_dvs,
    output logic        o_valid,
    output t_ctx        o_ctx,
    output logic [63:0] o_quo
);

    logic        r_v   [DIV_STEPS];
    t_ctx        r_ctx [DIV_STEPS];
    logic [63:0] r_rem [DIV_STEPS];
    logic [63:0] r_dq  [DIV_STEPS];
    logic [63:0] r_dvs [DIV_STEPS];

    logic        w_v   [DIV_STEPS];
    t_ctx        w_ctx [DIV_STEPS];
    logic [63:0] w_rem [DIV_STEPS];
    logic [63:0] w_dq  [DIV_STEPS];
    logic [63:0] w_dvs [DIV_STEPS];
    logic [63:0] n_rem [DIV_STEPS];
    logic [63:0] n_dq  [DIV_STEPS];

    always_comb begin
        w_v[0]   = i_valid;
        w_ctx[0] = i_ctx;
        w_rem[0] = i_rem;
        w_dq[0]  = i_dvd;
        w_dvs[0] = i_dvs;
        for (int k = 1; k < DIV_STEPS; k++) begin
            w_v[k]   = r_v[k-1];
            w_ctx[k] = r_ctx[k-1];
            w_rem[k] = r_rem[k-1];
            w_dq[k]  = r_dq[k-1];
            w_dvs[k] = r_dvs[k-1];
        end
    end

    always_comb begin
        logic [64:0] trial;
        logic        ge;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial    = {w_rem[k], w_dq[k][63]};
            ge       = (trial >= {1'b0, w_dvs[k]});
            n_rem[k] = ge ? 64'(trial - {1'b0, w_dvs[k]}) : trial[63:0];
            n_dq[k]  = {w_dq[k][62:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v[k];
            end
            if (i_en) begin
                r_ctx[k] <= w_ctx[k];
                r_rem[k] <= n_rem[k];
                r_dq[k]  <= n_dq[k];
                r_dvs[k] <= w_dvs[k];
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_ctx   = r_ctx[DIV_STEPS-1];
    assign o_quo   = r_dq[DIV_STEPS-1];

endmodule

>>> src/mirror_coordinate_transform.sv
// top level of the mirror coordinate transform
// Converts one signed Q16.16 coordinate per transfer between cartesian x and the
// mirror-field curvilinear q, or scales it linearly in uniform mode, and returns
// the result with a status (ok, angle out of domain, saturated). Items are taken
// at one per cycle while the output buffer has room. Each passes through five
// setup stages, the 24-stage cordic, and two 64-stage restoring dividers with a
// stage before each. The whole pipeline advances together and stops only while
// its two-entry output buffer is full, so input ready stays high while one result
// waits. The user must write registers only with no item in flight (not enforced).
module mirror_coordinate_transform import mct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    mct_in_if.sink      i_item,
    mct_out_if.source   o_result
);

    // configuration registers
    logic        r_uniform;
    logic [31:0] r_xi, r_d1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uniform <= 1'b0;
            r_xi      <= 32'h0100_0000;
            r_d1      <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UNIFORM: r_uniform <= i_cfg_data[0];
                CFG_CURV:    r_xi      <= i_cfg_data;
                CFG_SPACING: r_d1      <= i_cfg_data;
                default:     r_uniform <= r_uniform;
            endcase
        end
    end

    logic [1:0] r_cnt;
    logic       en;

    assign en           = (r_cnt != 2'd2);
    assign i_item.ready = en;

    // front and rotator
    logic p_valid, c_valid;
    t_ctx p_ctx, c_ctx;
    t_rot p_rot, c_rot;

    mct_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_item.valid),
        .i_cmd     (i_item.cmd),
        .i_coord   (i_item.coord_in),
        .i_uniform (r_uniform),
        .i_xi      (r_xi),
        .i_d1      (r_d1),
        .o_valid   (p_valid),
        .o_ctx     (p_ctx),
        .o_rot     (p_rot)
    );

    mct_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_ctx   (p_ctx),
        .i_rot   (p_rot),
        .o_valid (c_valid),
        .o_ctx   (c_ctx),
        .o_rot   (c_rot)
    );

    // first divider setup
    logic        r_a_v;
    t_ctx        r_a_ctx;
    logic [63:0] r_a_dvd, r_a_dvs;
    t_ctx        n_a_ctx;
    logic [63:0] n_a_dvd, n_a_dvs, n_a_prod;
    logic [30:0] n_a_ang;
    logic [31:0] n_a_sin;

    assign n_a_prod = r_xi * r_d1;

    always_comb begin
        n_a_ctx = c_ctx;
        n_a_dvd = '0;
        n_a_dvs = 64'd1;
        n_a_ang = '0;
        n_a_sin = '0;
        case (c_ctx.op)
            OP_DIVU: begin
                n_a_dvd = {16'b0, c_ctx.res[31:0], 16'b0};
                n_a_dvs = {32'b0, r_d1};
            end
            OP_ATAN: begin
                if (c_rot.z < 0) begin
                    n_a_ang = '0;
                end else if (c_rot.z > $signed({2'b0, HALF_PI_Q30})) begin
                    n_a_ang = HALF_PI_Q30;
                end else begin
                    n_a_ang = c_rot.z[30:0];
                end
                n_a_dvd = {7'b0, n_a_ang, 26'b0};
                n_a_dvs = n_a_prod;
            end
            OP_TAN: begin
                if (c_rot.x <= 0) begin
                    n_a_ctx.op  = OP_DONE;
                    n_a_ctx.st  = ST_SAT;
                    n_a_ctx.res = RES_SAT;
                end else begin
                    n_a_sin = (c_rot.y < 0) ? 32'd0 : c_rot.y[31:0];
                    n_a_dvd = {n_a_sin, 32'b0};
                    n_a_dvs = {28'b0, c_rot.x};
                end
            end
            default: begin
                n_a_ctx = c_ctx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= c_valid;
        end
        if (en) begin
            r_a_ctx <= n_a_ctx;
            r_a_dvd <= n_a_dvd;
            r_a_dvs <= n_a_dvs;
        end
    end

    logic        d1_valid;
    t_ctx        d1_ctx;
    logic [63:0] d1_quo;

    mct_div u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_v),
        .i_ctx   (r_a_ctx),
        .i_rem   (64'd0),
        .i_dvd   (r_a_dvd),
        .i_dvs   (r_a_dvs),
        .o_valid (d1_valid),
        .o_ctx   (d1_ctx),
        .o_quo   (d1_quo)
    );

    // second divider setup, tangent over curvature
    logic        r_b_v;
    t_ctx        r_b_ctx;
    logic [63:0] r_b_rem, r_b_dvd, r_b_dvs;
    t_ctx        n_b_ctx;
    logic [63:0] n_b_rem, n_b_dvd, n_b_dvs;

    always_comb begin
        n_b_ctx = d1_ctx;
        n_b_rem = '0;
        n_b_dvd = '0;
        n_b_dvs = 64'd1;
        case (d1_ctx.op)
            OP_DIVU, OP_ATAN: begin
                n_b_ctx.op  = OP_DONE;
                n_b_ctx.res = f_code33(d1_quo);
            end
            OP_TAN: begin
                if (d1_quo[63:25] >= {7'b0, r_xi}) begin
                    n_b_ctx.op  = OP_DONE;
                    n_b_ctx.st  = ST_SAT;
                    n_b_ctx.res = RES_SAT;
                end else begin
                    n_b_rem = {25'b0, d1_quo[63:25]};
                    n_b_dvd = {d1_quo[24:0], 39'b0};
                    n_b_dvs = {32'b0, r_xi};
                end
            end
            default: begin
                n_b_ctx = d1_ctx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= d1_valid;
        end
        if (en) begin
            r_b_ctx <= n_b_ctx;
            r_b_rem <= n_b_rem;
            r_b_dvd <= n_b_dvd;
            r_b_dvs <= n_b_dvs;
        end
    end

    logic        d2_valid;
    t_ctx        d2_ctx;
    logic [63:0] d2_quo;

    mct_div u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_v),
        .i_ctx   (r_b_ctx),
        .i_rem   (r_b_rem),
        .i_dvd   (r_b_dvd),
        .i_dvs   (r_b_dvs),
        .o_valid (d2_valid),
        .o_ctx   (d2_ctx),
        .o_quo   (d2_quo)
    );

    // sign and saturation
    logic [32:0] e_res;
    logic [31:0] e_mag, e_coord;
    logic [1:0]  e_st;

    always_comb begin
        e_res = d2_ctx.res;
        e_st  = d2_ctx.st;
        if (d2_ctx.op == OP_TAN) begin
            e_res = f_code33({31'b0, d2_quo[63:31]});
            e_st  = ST_OK;
        end
        e_mag = e_res[31:0];
        if (d2_ctx.neg) begin
            if (e_res > 33'h0_8000_0000) begin
                e_mag = 32'h8000_0000;
                e_st  = (e_st == ST_OK) ? ST_SAT : e_st;
            end
            e_coord = 32'(-e_mag);
        end else begin
            if (e_res > 33'h0_7FFF_FFFF) begin
                e_mag = 32'h7FFF_FFFF;
                e_st  = (e_st == ST_OK) ? ST_SAT : e_st;
            end
            e_coord = e_mag;
        end
    end

    // output buffer
    logic [31:0] r_buf_coord [2];
    logic [1:0]  r_buf_st    [2];
    logic        r_wr, r_rd;
    logic        push, pop;

    assign push = en && d2_valid;
    assign pop  = o_result.valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf_coord[r_wr] <= e_coord;
            r_buf_st[r_wr]    <= e_st;
        end
    end

    assign o_result.valid     = (r_cnt != '0);
    assign o_result.coord_out = $signed(r_buf_coord[r_rd]);
    assign o_result.status    = r_buf_st[r_rd];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == 2'($past(r_cnt) + 2'd1)))
        else $error("output buffer count missed a write");

    a_cnt_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_cnt == 2'($past(r_cnt) - 2'd1)))
        else $error("output buffer count missed a read");

    a_status_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.status != ST_OK)) |->
        (r_buf_coord[r_rd] == 32'h7FFF_FFFF || r_buf_coord[r_rd] == 32'h8000_0000))
        else $error("error status without a saturated coordinate");

endmodule

>>> test/mct_checker.sv
// checker for the mirror coordinate transform: predicts each result and compares it
module mct_checker import mct_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    mct_in_if          i_item,
    mct_out_if         i_result,
    output int         o_errors,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] coord;
        logic [1:0]  status;
    } t_expect;

    logic        uniform_q;
    logic [31:0] curv_q;
    logic [31:0] spacing_q;
    t_expect     expected_q[$];

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic t_expect pack_result(input bit neg, input logic [63:0] mag,
                                            input logic [1:0] st);
        t_expect r;
        logic [1:0] s;
        s = st;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                mag = 64'h8000_0000;
                if (s == ST_OK) s = ST_SAT;
            end
            r.coord = 32'(64'd0 - mag);
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                mag = 64'h7FFF_FFFF;
                if (s == ST_OK) s = ST_SAT;
            end
            r.coord = mag[31:0];
        end
        r.status = s;
        return r;
    endfunction

    function automatic logic [63:0] arctan_q30(input logic [63:0] num, input logic [63:0] den);
        longint x, y, z, nx;
        z = 0;
        while (num >= 64'h1_0000_0000 || den >= 64'h1_0000_0000) begin
            num = num >> 1;
            den = den >> 1;
        end
        if (num == 0) return 0;
        x = longint'(den);
        y = longint'(num);
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            if (y > 0) begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += longint'(ATAN_Q30[i]);
            end else begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= longint'(ATAN_Q30[i]);
            end
            x = nx;
        end
        if (z < 0) z = 0;
        if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
        return 64'(z);
    endfunction

    function automatic t_expect transform(input logic cmd, input logic [31:0] raw);
        bit neg;
        logic [63:0] mag, xi, d1, ang, p, hi, lo, theta, t, qa, res;
        longint x, y, z, nx;
        neg = raw[31];
        mag = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
        xi = {32'd0, curv_q};
        d1 = {32'd0, spacing_q};
        if (uniform_q || xi == 0) begin
            if (cmd == CMD_TO_CURV) begin
                if (mag == 0) return pack_result(0, 0, ST_OK);
                if (d1 == 0) return pack_result(neg, '1, ST_SAT);
                return pack_result(neg, (mag << 16) / d1, ST_OK);
            end
            return pack_result(neg, (mag * d1) >> 16, ST_OK);
        end
        if (cmd == CMD_TO_CURV) begin
            if (mag == 0) return pack_result(0, 0, ST_OK);
            if (d1 == 0) return pack_result(neg, '1, ST_SAT);
            ang = arctan_q30(xi * mag, 64'd1 << 40);
            return pack_result(neg, (ang << 26) / (xi * d1), ST_OK);
        end
        if (mag == 0 || d1 == 0) return pack_result(0, 0, ST_OK);
        p = xi * d1;
        hi = (p >> 32) * mag;
        lo = (p & 64'hFFFF_FFFF) * mag;
        if (hi >= (64'd1 << 25)) return pack_result(neg, '1, ST_DOMAIN);
        theta = (hi << 6) + (lo >> 26);
        if (theta >= HALF_PI_Q30) return pack_result(neg, '1, ST_DOMAIN);
        if (theta == 0) return pack_result(0, 0, ST_OK);
        x = 64'sd1 << 30;
        y = 0;
        z = longint'(theta);
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= longint'(ATAN_Q30[i]);
            end else begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += longint'(ATAN_Q30[i]);
            end
            x = nx;
        end
        if (x <= 0) return pack_result(neg, '1, ST_SAT);
        if (y < 0) y = 0;
        t = (64'(y) << 32) / 64'(x);
        qa = t / xi;
        if (qa > 64'h8000_0000) return pack_result(neg, '1, ST_SAT);
        res = qa * 256 + ((t % xi) * 256) / xi;
        return pack_result(neg, res, ST_OK);
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_expect e;
        if (!i_rst_n) begin
            uniform_q <= 1'b0;
            curv_q <= 32'h0100_0000;
            spacing_q <= 32'h0001_0000;
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_UNIFORM: uniform_q <= i_cfg_data[0];
                    CFG_CURV:    curv_q <= i_cfg_data;
                    CFG_SPACING: spacing_q <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result coord %h status %0d", $time,
                             i_result.coord_out, i_result.status);
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e.coord !== i_result.coord_out || e.status !== i_result.status) begin
                        $display("%0t: mismatch expected coord %h status %0d, got %h status %0d",
                                 $time, e.coord, e.status, i_result.coord_out, i_result.status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_item.valid && i_item.ready)
                expected_q.push_back(transform(i_item.cmd, i_item.coord_in));
        end
    end
endmodule

>>> test/testbench.sv
// top of the mirror coordinate transform testbench: stimulus and verdict
module testbench;
    import mct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_UNIFORM;
    logic [31:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off = 1'b0;

    mct_in_if  item_if();
    mct_out_if result_if();

    mirror_coordinate_transform DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_item(item_if.sink), .o_result(result_if.source)
    );

    mct_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_item(item_if), .i_result(result_if),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        item_if.valid = 1'b0;
        item_if.cmd = 1'b0;
        item_if.coord_in = '0;
        result_if.ready = 1'b0;
    end

    always @(negedge i_clk)
        result_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_mode(input logic uni, input logic [31:0] xi, input logic [31:0] d1);
        write_reg(CFG_UNIFORM, {31'd0, uni});
        write_reg(CFG_CURV, xi);
        write_reg(CFG_SPACING, d1);
    endtask

    // one transfer, with random idle cycles before it
    task automatic send_coord(input logic cmd, input logic [31:0] coord);
        while ($urandom_range(99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.cmd <= cmd;
        item_if.coord_in <= coord;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2 * 65536)) - 65536);
            2: return 32'($signed($urandom_range(2000)) - 1000);
            3: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
            4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(40 * 65536)) - 20 * 65536);
        endcase
    endfunction

    function automatic logic [31:0] rand_param();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'h0001_0000 + $urandom_range(65536) - 32768;
            2: return $urandom_range(1 << 20);
            3: return 32'h0100_0000 + $urandom_range(1 << 24) - (1 << 23);
            default: return $urandom_range(255) << $urandom_range(24);
        endcase
    endfunction

    task automatic random_phase(input int n);
        set_mode($urandom_range(3) == 0, rand_param(), rand_param() | 32'd1);
        repeat (n) send_coord(1'($urandom_range(1)), rand_coord());
        drain();
    endtask

    initial begin
        send_idle_pct = 6;
        recv_idle_pct = 79;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings, extremes, special cases
        send_coord(CMD_TO_CURV, 32'h0001_0000);
        send_coord(CMD_TO_CART, 32'h0001_0000);
        send_coord(CMD_TO_CURV, 32'h0);
        send_coord(CMD_TO_CART, 32'h0);
        send_coord(CMD_TO_CURV, 32'h7FFF_FFFF);
        send_coord(CMD_TO_CART, 32'h8000_0000);
        send_coord(CMD_TO_CART, 32'h0001_9220);
        send_coord(CMD_TO_CART, 32'hFFFE_6DE0);
        send_coord(CMD_TO_CART, 32'h0001_921F);
        send_coord(CMD_TO_CURV, 32'hFFFF_FFFF);
        drain();
        set_mode(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_coord(CMD_TO_CURV, 32'h7FFF_FFFF);
        send_coord(CMD_TO_CART, 32'h8000_0000);
        send_coord(CMD_TO_CART, 32'h0000_0001);
        drain();
        set_mode(1'b0, 32'h0, 32'h0);
        send_coord(CMD_TO_CURV, 32'h0001_0000);
        send_coord(CMD_TO_CURV, 32'h0);
        send_coord(CMD_TO_CART, 32'h8000_0000);
        drain();
        set_mode(1'b0, 32'hFFFF_FFFF, 32'h0);
        send_coord(CMD_TO_CURV, 32'hFFF0_0000);
        send_coord(CMD_TO_CART, 32'h0001_0000);
        drain();
        set_mode(1'b0, 32'h0000_0001, 32'h0000_0001);
        send_coord(CMD_TO_CURV, 32'h7FFF_FFFF);
        send_coord(CMD_TO_CART, 32'h8000_0000);
        send_coord(CMD_TO_CART, 32'h0000_0001);
        drain();

        for (int ph = 0; ph < 3; ph++) random_phase(50);
        send_idle_pct = 79;
        recv_idle_pct = 6;
        for (int ph = 0; ph < 3; ph++) random_phase(50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int ph = 0; ph < 3; ph++) random_phase(50);

        // receiver holds off while items keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(200);
        join

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

>>> filelist.f
src/mct_pkg.sv
src/mct_in_if.sv
src/mct_out_if.sv
src/mct_prep.sv
src/mct_cordic.sv
src/mct_div.sv
src/mirror_coordinate_transform.sv
test/mct_checker.sv
test/testbench.sv
